FILE: design/bdf_pkg.sv
// Package: types, constants and the square-root step for the box distance field core.
package bdf_pkg;

	localparam int GRID_DIM_DEF  = 256;
	localparam int FRAC_BITS_DEF = 8;
	localparam int REG_W  = 21;
	localparam int CELL_W = 8;
	localparam int DIST_W = 22;
	localparam int REG_CNT = 6;
	localparam int CRD_W  = 23;
	localparam int SQ_W   = 48;
	localparam int SQS_W  = 50;
	localparam int ROOT_W = 25;
	localparam int SQRT_STEPS = SQS_W / 2;
	localparam int SQRT_STG = 5;
	localparam int STEPS_PER_STG = SQRT_STEPS / SQRT_STG;

	localparam logic [2:0] ADDR_LO_X = 3'd0;
	localparam logic [2:0] ADDR_LO_Y = 3'd1;
	localparam logic [2:0] ADDR_LO_Z = 3'd2;
	localparam logic [2:0] ADDR_HI_X = 3'd3;
	localparam logic [2:0] ADDR_HI_Y = 3'd4;
	localparam logic [2:0] ADDR_HI_Z = 3'd5;

	localparam logic [2:0] REG_INSIDE = 3'd0;
	localparam logic [2:0] REG_FACE_X = 3'd1;
	localparam logic [2:0] REG_FACE_Y = 3'd2;
	localparam logic [2:0] REG_FACE_Z = 3'd3;
	localparam logic [2:0] REG_EDGE_X = 3'd4;
	localparam logic [2:0] REG_EDGE_Y = 3'd5;
	localparam logic [2:0] REG_EDGE_Z = 3'd6;
	localparam logic [2:0] REG_CORNER = 3'd7;

	typedef struct packed {
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [CELL_W-1:0] cell_z;
	} cmd_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic [2:0]               region;
	} res_t;

	typedef struct packed {
		logic signed [REG_W-1:0] lo_x;
		logic signed [REG_W-1:0] lo_y;
		logic signed [REG_W-1:0] lo_z;
		logic signed [REG_W-1:0] hi_x;
		logic signed [REG_W-1:0] hi_y;
		logic signed [REG_W-1:0] hi_z;
	} box_t;

	// square-root working state
	typedef struct packed {
		logic [SQS_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	// one restoring digit, step k counted from the top pair
	function automatic sqrt_t sqrt_step(sqrt_t s, logic [SQS_W-1:0] v, int k);
		sqrt_t r;
		logic [SQS_W+1:0] trial;
		logic [SQS_W+1:0] cur;
		r = s;
		cur = {s.rem[SQS_W-1:0], v[SQS_W-1-2*k -: 2]};
		trial = {{(SQS_W-ROOT_W){1'b0}}, s.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = SQS_W'(cur - trial);
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = SQS_W'(cur);
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: design/box_distance_field_core.sv
// Top level: box signed distance field core with APB register file.
// Usage: write the six corner registers over APB (lo x/y/z at 0x00..0x08,
// hi x/y/z at 0x0C..0x14) while idle. Raise start with cmd holding one cell
// index; busy stays low, so a transaction is accepted every cycle.
// Each result appears on res for one cycle with done high. Between the accepting
// edge and done lie two front stages, five square-root stages (five digits each)
// and one output register.
// Throughput is one cell per cycle, set by the fully pipelined square root.
// Results leave in order.
// The receiver cannot stall; done is a pure strobe.
// Reset clears all valid bits and the corner registers to zero.
// distance saturates to the 22-bit signed range; region gives
// 0 inside, 1..3 face x/y/z, 4..6 edge x/y/z, 7 corner.
module box_distance_field_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bdf_pkg::cmd_t       cmd,
	output logic                done,
	output bdf_pkg::res_t       res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int CW = bdf_pkg::CRD_W;
	localparam int DW = bdf_pkg::DIST_W;

	bdf_pkg::box_t box_q;
	logic [2:0]    ridx;
	assign ridx   = paddr[4:2];
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) box_q <= '0;
		else if (psel && penable && pwrite) begin
			case (ridx)
				bdf_pkg::ADDR_LO_X: box_q.lo_x <= pwdata[bdf_pkg::REG_W-1:0];
				bdf_pkg::ADDR_LO_Y: box_q.lo_y <= pwdata[bdf_pkg::REG_W-1:0];
				bdf_pkg::ADDR_LO_Z: box_q.lo_z <= pwdata[bdf_pkg::REG_W-1:0];
				bdf_pkg::ADDR_HI_X: box_q.hi_x <= pwdata[bdf_pkg::REG_W-1:0];
				bdf_pkg::ADDR_HI_Y: box_q.hi_y <= pwdata[bdf_pkg::REG_W-1:0];
				bdf_pkg::ADDR_HI_Z: box_q.hi_z <= pwdata[bdf_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			bdf_pkg::ADDR_LO_X: prdata = 32'(box_q.lo_x);
			bdf_pkg::ADDR_LO_Y: prdata = 32'(box_q.lo_y);
			bdf_pkg::ADDR_LO_Z: prdata = 32'(box_q.lo_z);
			bdf_pkg::ADDR_HI_X: prdata = 32'(box_q.hi_x);
			bdf_pkg::ADDR_HI_Y: prdata = 32'(box_q.hi_y);
			bdf_pkg::ADDR_HI_Z: prdata = 32'(box_q.hi_z);
			default:            prdata = '0;
		endcase
	end

	logic                 f_v;
	logic [2:0]           f_rg;
	logic signed [CW-1:0] f_fd;
	logic [bdf_pkg::SQS_W-1:0] f_sq;

	bdf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .cmd(cmd), .box(box_q),
		.out_valid(f_v), .region(f_rg), .face_dist(f_fd), .sq_sum(f_sq)
	);

	logic                 s_v;
	logic [2:0]           s_rg;
	logic signed [CW-1:0] s_fd;
	logic [bdf_pkg::ROOT_W:0] s_root;

	bdf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(f_v), .value(f_sq), .in_region(f_rg),
		.in_face(f_fd), .out_valid(s_v), .out_region(s_rg), .out_face(s_fd), .root(s_root)
	);

	localparam logic signed [CW-1:0] DMAX = CW'((1 << (DW-1)) - 1);
	localparam logic signed [CW-1:0] DMIN = -CW'(1 << (DW-1));
	logic signed [CW-1:0] dsel;
	logic signed [DW-1:0] dsat;

	always_comb begin
		if (s_rg inside {bdf_pkg::REG_INSIDE, bdf_pkg::REG_FACE_X,
		                 bdf_pkg::REG_FACE_Y, bdf_pkg::REG_FACE_Z}) begin
			dsel = s_fd;
			if (dsel > DMAX)      dsat = DW'(DMAX);
			else if (dsel < DMIN) dsat = DW'(DMIN);
			else                  dsat = DW'(dsel);
		end else begin
			dsel = s_fd;
			if (s_root > (bdf_pkg::ROOT_W+1)'(DMAX)) dsat = DW'(DMAX);
			else                                    dsat = DW'(s_root);
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= s_v;
	end
	always_ff @(posedge clk) begin
		res.distance <= dsat;
		res.region   <= s_rg;
	end
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##8 done) else $error("result missing after latency");
	a_inside_neg: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.region == bdf_pkg::REG_INSIDE |-> res.distance <= 0)
		else $error("inside distance positive");
	a_edge_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.region >= bdf_pkg::REG_EDGE_X |-> !res.distance[DW-1])
		else $error("edge or corner distance negative");
`endif
endmodule

FILE: design/bdf_front.sv
// Front stages: cell centre, region classification, face distance and squared terms.
module bdf_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  bdf_pkg::cmd_t                        cmd,
	input  bdf_pkg::box_t                        box,
	output logic                                 out_valid,
	output logic [2:0]                           region,
	output logic signed [bdf_pkg::CRD_W-1:0]     face_dist,
	output logic [bdf_pkg::SQS_W-1:0]            sq_sum
);
	localparam int FRAC_BITS = bdf_pkg::FRAC_BITS_DEF;
	localparam int CW = bdf_pkg::CRD_W;
	localparam int SW = bdf_pkg::SQ_W;
	localparam logic signed [CW-1:0] HALF = CW'(1) <<< (FRAC_BITS - 1);

	logic signed [CW-1:0] p_s1 [3];
	logic signed [CW-1:0] lo_s1 [3];
	logic signed [CW-1:0] hi_s1 [3];
	logic                 v_s1;
	logic                 v_s2;
	logic [2:0]           reg_s2;
	logic signed [CW-1:0] fd_s2;
	logic [SW-1:0]        nsq_s2 [3];
	logic [2:0]           use_s2;

	logic [bdf_pkg::CELL_W-1:0] cidx [3];
	assign cidx[0] = cmd.cell_x;
	assign cidx[1] = cmd.cell_y;
	assign cidx[2] = cmd.cell_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= (CW'(cidx[0]) <<< FRAC_BITS) + HALF;
		p_s1[1] <= (CW'(cidx[1]) <<< FRAC_BITS) + HALF;
		p_s1[2] <= (CW'(cidx[2]) <<< FRAC_BITS) + HALF;
		lo_s1[0] <= CW'(box.lo_x); hi_s1[0] <= CW'(box.hi_x);
		lo_s1[1] <= CW'(box.lo_y); hi_s1[1] <= CW'(box.hi_y);
		lo_s1[2] <= CW'(box.lo_z); hi_s1[2] <= CW'(box.hi_z);
	end

	logic                 inc [3];
	logic                 str [3];
	logic signed [CW-1:0] fd [3];
	logic [SW-1:0]        nsq [3];
	logic signed [CW-1:0] da, db, fmax;
	logic [CW-1:0]        ma, mb;
	logic [SW-1:0]        qa, qb;
	logic [2:0]           rg;
	logic signed [CW-1:0] fsel;
	logic [2:0]           use_ax;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inc[i] = (p_s1[i] <= hi_s1[i]) && (p_s1[i] >= lo_s1[i]);
			str[i] = (p_s1[i] <  hi_s1[i]) && (p_s1[i] >  lo_s1[i]);
			da = p_s1[i] - hi_s1[i];
			db = lo_s1[i] - p_s1[i];
			fd[i] = (da > db) ? da : db;
			ma = da[CW-1] ? CW'(-da) : CW'(da);
			mb = db[CW-1] ? CW'(-db) : CW'(db);
			qa = SW'(ma) * SW'(ma);
			qb = SW'(mb) * SW'(mb);
			nsq[i] = (qb < qa) ? qb : qa;
		end
		fmax = (fd[0] > fd[1]) ? fd[0] : fd[1];
		fmax = (fmax > fd[2]) ? fmax : fd[2];
		fsel = fd[0];
		use_ax = 3'b111;
		if (inc[0] && inc[1] && inc[2]) begin
			rg = bdf_pkg::REG_INSIDE; fsel = fmax;
		end else if (inc[1] && inc[2]) begin
			rg = bdf_pkg::REG_FACE_X; fsel = fd[0];
		end else if (inc[0] && inc[2]) begin
			rg = bdf_pkg::REG_FACE_Y; fsel = fd[1];
		end else if (inc[0] && inc[1]) begin
			rg = bdf_pkg::REG_FACE_Z; fsel = fd[2];
		end else if (str[0]) begin
			rg = bdf_pkg::REG_EDGE_X; use_ax = 3'b011;
		end else if (str[1]) begin
			rg = bdf_pkg::REG_EDGE_Y; use_ax = 3'b101;
		end else if (str[2]) begin
			rg = bdf_pkg::REG_EDGE_Z; use_ax = 3'b110;
		end else begin
			rg = bdf_pkg::REG_CORNER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	// use_ax bit 2 is x, bit 0 is z
	always_ff @(posedge clk) begin
		reg_s2 <= rg;
		fd_s2  <= fsel;
		use_s2 <= use_ax;
		for (int i = 0; i < 3; i++) nsq_s2[i] <= nsq[i];
	end

	always_comb begin
		sq_sum = (use_s2[2] ? bdf_pkg::SQS_W'(nsq_s2[0]) : '0)
		       + (use_s2[1] ? bdf_pkg::SQS_W'(nsq_s2[1]) : '0)
		       + (use_s2[0] ? bdf_pkg::SQS_W'(nsq_s2[2]) : '0);
	end

	assign out_valid = v_s2;
	assign region    = reg_s2;
	assign face_dist = fd_s2;
endmodule

FILE: design/bdf_sqrt.sv
// Pipelined integer square root with rounding, a few digits per stage.
module bdf_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [bdf_pkg::SQS_W-1:0]          value,
	input  logic [2:0]                         in_region,
	input  logic signed [bdf_pkg::CRD_W-1:0]   in_face,
	output logic                               out_valid,
	output logic [2:0]                         out_region,
	output logic signed [bdf_pkg::CRD_W-1:0]   out_face,
	output logic [bdf_pkg::ROOT_W:0]           root
);
	localparam int NS = bdf_pkg::SQRT_STG;
	localparam int PS = bdf_pkg::STEPS_PER_STG;

	bdf_pkg::sqrt_t             st_q  [NS+1];
	logic [bdf_pkg::SQS_W-1:0]  val_q [NS+1];
	logic [2:0]                 rg_q  [NS+1];
	logic signed [bdf_pkg::CRD_W-1:0] fd_q [NS+1];
	logic                       v_q   [NS+1];

	always_comb begin
		st_q[0]  = '0;
		val_q[0] = value;
		rg_q[0]  = in_region;
		fd_q[0]  = in_face;
		v_q[0]   = in_valid;
	end

	for (genvar g = 0; g < NS; g++) begin : g_stg
		bdf_pkg::sqrt_t nx;
		always_comb begin
			nx = st_q[g];
			for (int k = 0; k < PS; k++) nx = bdf_pkg::sqrt_step(nx, val_q[g], g*PS + k);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[g+1] <= 1'b0;
			else         v_q[g+1] <= v_q[g];
		end
		always_ff @(posedge clk) begin
			st_q[g+1]  <= nx;
			val_q[g+1] <= val_q[g];
			rg_q[g+1]  <= rg_q[g];
			fd_q[g+1]  <= fd_q[g];
		end
	end

	// round up when remainder exceeds root
	assign root = (st_q[NS].rem > bdf_pkg::SQS_W'(st_q[NS].root))
		? {1'b0, st_q[NS].root} + 1'b1 : {1'b0, st_q[NS].root};
	assign out_valid  = v_q[NS];
	assign out_region = rg_q[NS];
	assign out_face   = fd_q[NS];
endmodule

FILE: tb/box_distance_field_core_test.sv
// Testbench for the box distance field core: directed and random cells against a box predictor.
module box_distance_field_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = bdf_pkg::FRAC_BITS_DEF;
	localparam int RW = bdf_pkg::REG_W;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	// Expected results in order; compares each strobed result with the oldest one.
	class distance_scoreboard;
		bdf_pkg::res_t pending[$];
		int errors;
		bdf_pkg::box_t box = '0;

		function longint sq(longint d);
			return d * d;
		endfunction

		function longint near_sq(longint p, longint lo, longint hi);
			longint a, b;
			a = sq(lo - p);
			b = sq(hi - p);
			return (a < b) ? a : b;
		endfunction

		function longint face(longint p, longint lo, longint hi);
			return (p - hi > lo - p) ? p - hi : lo - p;
		endfunction

		function longint root_rounded(longint v);
			longint r;
			r = 0;
			for (longint step = 64'd1 << 30; step > 0; step >>= 1)
				if ((r + step) * (r + step) <= v)
					r += step;
			if (v - r * r > r)
				r++;
			return r;
		endfunction

		function bdf_pkg::res_t predict(bdf_pkg::cmd_t c);
			bdf_pkg::res_t o;
			longint px, py, pz, lx, ly, lz, hx, hy, hz, d;
			bit ix, iy, iz;
			px = (longint'(c.cell_x) << FB) + (1 << (FB - 1));
			py = (longint'(c.cell_y) << FB) + (1 << (FB - 1));
			pz = (longint'(c.cell_z) << FB) + (1 << (FB - 1));
			lx = box.lo_x; ly = box.lo_y; lz = box.lo_z;
			hx = box.hi_x; hy = box.hi_y; hz = box.hi_z;
			ix = px <= hx && px >= lx;
			iy = py <= hy && py >= ly;
			iz = pz <= hz && pz >= lz;
			if (ix && iy && iz) begin
				d = face(px, lx, hx);
				if (face(py, ly, hy) > d) d = face(py, ly, hy);
				if (face(pz, lz, hz) > d) d = face(pz, lz, hz);
				o.region = bdf_pkg::REG_INSIDE;
			end else if (iy && iz) begin
				d = face(px, lx, hx);
				o.region = bdf_pkg::REG_FACE_X;
			end else if (ix && iz) begin
				d = face(py, ly, hy);
				o.region = bdf_pkg::REG_FACE_Y;
			end else if (ix && iy) begin
				d = face(pz, lz, hz);
				o.region = bdf_pkg::REG_FACE_Z;
			end else if (px > lx && px < hx) begin
				d = root_rounded(near_sq(py, ly, hy) + near_sq(pz, lz, hz));
				o.region = bdf_pkg::REG_EDGE_X;
			end else if (py > ly && py < hy) begin
				d = root_rounded(near_sq(px, lx, hx) + near_sq(pz, lz, hz));
				o.region = bdf_pkg::REG_EDGE_Y;
			end else if (pz > lz && pz < hz) begin
				d = root_rounded(near_sq(px, lx, hx) + near_sq(py, ly, hy));
				o.region = bdf_pkg::REG_EDGE_Z;
			end else begin
				d = root_rounded(near_sq(px, lx, hx) + near_sq(py, ly, hy)
					+ near_sq(pz, lz, hz));
				o.region = bdf_pkg::REG_CORNER;
			end
			if (d > 2097151) d = 2097151;
			if (d < -2097152) d = -2097152;
			o.distance = d[bdf_pkg::DIST_W-1:0];
			return o;
		endfunction

		function void note_cell(bdf_pkg::cmd_t c);
			pending = {pending, predict(c)};
		endfunction

		function void check_result(bdf_pkg::res_t got);
			bdf_pkg::res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result dist=%0d region=%0d", got.distance, got.region);
				return;
			end
			want = pending.pop_front();
			if (got.distance !== want.distance || got.region !== want.region) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected dist=%0d region=%0d, got dist=%0d region=%0d",
						want.distance, want.region, got.distance, got.region);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	bdf_pkg::cmd_t cmd = '0;
	logic done;
	bdf_pkg::res_t res;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	distance_scoreboard board = new();
	int idle_cycles;
	bit allow_gaps = 1;

	box_distance_field_core DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (done)
			board.check_result(res);
		if ((start && !busy) || done || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic signed [RW-1:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		case (idx)
			bdf_pkg::ADDR_LO_X: board.box.lo_x = val;
			bdf_pkg::ADDR_LO_Y: board.box.lo_y = val;
			bdf_pkg::ADDR_LO_Z: board.box.lo_z = val;
			bdf_pkg::ADDR_HI_X: board.box.hi_x = val;
			bdf_pkg::ADDR_HI_Y: board.box.hi_y = val;
			bdf_pkg::ADDR_HI_Z: board.box.hi_z = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic load_box(bdf_pkg::box_t b);
		write_reg(bdf_pkg::ADDR_LO_X, b.lo_x);
		write_reg(bdf_pkg::ADDR_LO_Y, b.lo_y);
		write_reg(bdf_pkg::ADDR_LO_Z, b.lo_z);
		write_reg(bdf_pkg::ADDR_HI_X, b.hi_x);
		write_reg(bdf_pkg::ADDR_HI_Y, b.hi_y);
		write_reg(bdf_pkg::ADDR_HI_Z, b.hi_z);
	endtask

	// Called at a falling edge; returns at the next falling edge after acceptance.
	task automatic send_cell(bdf_pkg::cmd_t c);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start <= 1;
		cmd <= c;
		do @(posedge clk); while (busy);
		board.note_cell(c);
		@(negedge clk);
	endtask

	// Called at a falling edge; drop start before the next rising edge.
	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic bdf_pkg::cmd_t cell_of(int x, int y, int z);
		bdf_pkg::cmd_t c;
		c.cell_x = bdf_pkg::CELL_W'(x);
		c.cell_y = bdf_pkg::CELL_W'(y);
		c.cell_z = bdf_pkg::CELL_W'(z);
		return c;
	endfunction

	function automatic bdf_pkg::box_t box_of(int lx, int ly, int lz, int hx, int hy, int hz);
		bdf_pkg::box_t b;
		b.lo_x = RW'(lx); b.lo_y = RW'(ly); b.lo_z = RW'(lz);
		b.hi_x = RW'(hx); b.hi_y = RW'(hy); b.hi_z = RW'(hz);
		return b;
	endfunction

	function automatic logic signed [RW-1:0] coord_near(int span);
		// mostly on or around the grid, sometimes anywhere
		if ($urandom_range(0, 7) == 0)
			return RW'($urandom);
		return RW'($urandom_range(0, span) - 1024 +
			($urandom_range(0, 1) ? 128 : 0));
	endfunction

	function automatic bdf_pkg::box_t random_box();
		bdf_pkg::box_t b;
		b.lo_x = coord_near(40000); b.lo_y = coord_near(40000); b.lo_z = coord_near(40000);
		b.hi_x = coord_near(70000); b.hi_y = coord_near(70000); b.hi_z = coord_near(70000);
		return b;
	endfunction

	function automatic bdf_pkg::cmd_t random_cell();
		bdf_pkg::cmd_t c;
		c = bdf_pkg::cmd_t'(24'($urandom));
		return c;
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// reset box: degenerate at origin, every cell is a corner
		send_cell(cell_of(0, 0, 0));
		send_cell(cell_of(255, 255, 255));
		drain();

		// box from cell 10 to 100 on x and z, 10 to 99 on y; exact centre hits on x and z give inclusive/strict edges
		load_box(box_of(10 * 256 + 128, 10 * 256, 10 * 256 + 128,
			100 * 256 + 128, 100 * 256, 100 * 256 + 128));
		send_cell(cell_of(50, 50, 50));
		send_cell(cell_of(10, 50, 50));
		send_cell(cell_of(100, 50, 10));
		send_cell(cell_of(200, 50, 50));
		send_cell(cell_of(50, 200, 50));
		send_cell(cell_of(50, 50, 0));
		send_cell(cell_of(50, 0, 0));
		send_cell(cell_of(0, 50, 255));
		send_cell(cell_of(0, 0, 50));
		send_cell(cell_of(10, 0, 10));
		send_cell(cell_of(0, 0, 0));
		send_cell(cell_of(255, 255, 255));
		drain();

		// extreme corners: far away saturates nothing but stresses the root
		load_box(box_of(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575));
		send_cell(cell_of(0, 0, 0));
		send_cell(cell_of(255, 128, 3));
		drain();
		load_box(box_of(1048575, 1048575, 1048575, -1048576, -1048576, -1048576));
		send_cell(cell_of(0, 0, 0));
		send_cell(cell_of(255, 255, 255));
		drain();
		load_box(box_of(-1048576, -1048576, -1048576, -1048576, -1048576, -1048576));
		send_cell(cell_of(255, 255, 255));
		drain();
		// inverted on one axis only
		load_box(box_of(60000, 0, 0, 1000, 65535, 65535));
		send_cell(cell_of(20, 20, 20));
		send_cell(cell_of(250, 20, 20));
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			load_box(random_box());
			allow_gaps = (phase < 10);
			for (int i = 0; i < 32; i++)
				send_cell(random_cell());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
design/bdf_pkg.sv
design/bdf_front.sv
design/bdf_sqrt.sv
design/box_distance_field_core.sv
tb/box_distance_field_core_test.sv
